// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; clocked on clk, quiet while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tcpq_pkg.sv =====
// shared types and codes of the three-class priority queue server
// no dependencies
package tcpq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE   = 1'b1;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_HI   = 2'd1;
  localparam logic [1:0] CLASS_MID  = 2'd2;
  localparam logic [1:0] CLASS_LO   = 2'd3;

  localparam int NUM_CLASSES = 3;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  entry_class;
    logic [2:0]  service_time;
    logic [15:0] arrival_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  item_class;
    logic [2:0]  item_service_time;
    logic [15:0] wait_time;
    logic [15:0] finish_time;
    logic [3:0]  occupancy;
    logic [15:0] class_drop_count;
    logic [15:0] class_served_count;
    logic [31:0] class_wait_sum;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture item and pick the best waiting entry
    logic commit;  // update queue state and load the result register
  } cmd_t;

endpackage

// ===== design/tcpq_datapath.sv =====
// queue cells, pick logic, server clock and per-class counters
// depends on tcpq_pkg
module tcpq_datapath #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  tcpq_pkg::cmd_t cmd,
  input  tcpq_pkg::req_t req,
  output tcpq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int CI = $clog2(tcpq_pkg::NUM_CLASSES);

  // queue cells in arrival order
  logic [1:0]  slot_class   [QUEUE_DEPTH];
  logic [2:0]  slot_service [QUEUE_DEPTH];
  logic [15:0] slot_arrival [QUEUE_DEPTH];
  logic [CW-1:0] waiting_count;
  logic [15:0]   server_time;
  logic [15:0]   drops_per_class    [tcpq_pkg::NUM_CLASSES];
  logic [15:0]   served_per_class   [tcpq_pkg::NUM_CLASSES];
  logic [31:0]   wait_sum_per_class [tcpq_pkg::NUM_CLASSES];

  // captured item and pick
  logic                   op_r;
  logic [1:0]             cls_r;
  logic [2:0]             svc_r;
  logic [15:0]            arr_r;
  logic [QUEUE_DEPTH-1:0] shift_r;
  logic [1:0]             p_cls_r;
  logic [2:0]             p_svc_r;
  logic [15:0]            p_arr_r;

  // pick logic
  logic [QUEUE_DEPTH-1:0] hit_hi, hit_mid, hit_lo, cand, pick_oh;
  logic [1:0]  p_cls;
  logic [2:0]  p_svc;
  logic [15:0] p_arr;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit_hi[i]  = (CW'(i) < waiting_count) && (slot_class[i] == tcpq_pkg::CLASS_HI);
      hit_mid[i] = (CW'(i) < waiting_count) && (slot_class[i] == tcpq_pkg::CLASS_MID);
      hit_lo[i]  = (CW'(i) < waiting_count) && (slot_class[i] == tcpq_pkg::CLASS_LO);
    end
    if (|hit_hi) begin
      cand = hit_hi;
    end else if (|hit_mid) begin
      cand = hit_mid;
    end else begin
      cand = hit_lo;
    end
    // oldest candidate
    pick_oh = cand & (~cand + QUEUE_DEPTH'(1));
    p_cls = '0;
    p_svc = '0;
    p_arr = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      p_cls = p_cls | ({2{pick_oh[i]}} & slot_class[i]);
      p_svc = p_svc | ({3{pick_oh[i]}} & slot_service[i]);
      p_arr = p_arr | ({16{pick_oh[i]}} & slot_arrival[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req.opcode;
      cls_r   <= req.entry_class;
      svc_r   <= req.service_time;
      arr_r   <= req.arrival_time;
      // cells at and above the pick take their upper neighbor
      shift_r <= ~(pick_oh - QUEUE_DEPTH'(1));
      p_cls_r <= p_cls;
      p_svc_r <= p_svc;
      p_arr_r <= p_arr;
    end
  end

  // commit logic
  logic          is_enq, cls_ok, q_empty, q_full;
  logic          enq_ok, drop_cls, srv_ok;
  logic [1:0]    res_cls, res_status;
  logic [CI-1:0] cidx;
  logic [15:0]   start, wait_t, fin;
  logic [16:0]   fin_sum;
  logic [32:0]   wsum_sum;
  logic [15:0]   drop_new, served_new;
  logic [31:0]   wsum_new;
  logic [CW-1:0] count_next;
  logic [15:0]   server_time_next;

  always_comb begin
    is_enq   = (op_r == tcpq_pkg::OP_ENQUEUE);
    cls_ok   = (cls_r != tcpq_pkg::CLASS_NONE);
    q_empty  = (waiting_count == '0);
    q_full   = (waiting_count == CW'(QUEUE_DEPTH));
    enq_ok   = is_enq && cls_ok && !q_full;
    drop_cls = is_enq && cls_ok && q_full;
    srv_ok   = !is_enq && !q_empty;

    if (is_enq) begin
      res_cls    = cls_r;
      res_status = enq_ok ? tcpq_pkg::ST_ACCEPTED : tcpq_pkg::ST_DROPPED;
    end else if (q_empty) begin
      res_cls    = tcpq_pkg::CLASS_NONE;
      res_status = tcpq_pkg::ST_EMPTY;
    end else begin
      res_cls    = p_cls_r;
      res_status = tcpq_pkg::ST_SERVED;
    end
    cidx = CI'(res_cls - 2'd1);

    start   = (server_time > p_arr_r) ? server_time : p_arr_r;
    wait_t  = start - p_arr_r;
    fin_sum = {1'b0, start} + 17'(p_svc_r);
    fin     = fin_sum[16] ? 16'hFFFF : fin_sum[15:0];

    drop_new   = drops_per_class[cidx];
    served_new = served_per_class[cidx];
    wsum_new   = wait_sum_per_class[cidx];
    wsum_sum   = {1'b0, wait_sum_per_class[cidx]} + 33'(wait_t);
    if (drop_cls && (drop_new != 16'hFFFF)) begin
      drop_new = drop_new + 16'd1;
    end
    if (srv_ok) begin
      if (served_new != 16'hFFFF) begin
        served_new = served_new + 16'd1;
      end
      wsum_new = wsum_sum[32] ? 32'hFFFF_FFFF : wsum_sum[31:0];
    end

    count_next       = waiting_count;
    server_time_next = server_time;
    if (enq_ok) begin
      count_next = waiting_count + CW'(1);
    end else if (srv_ok) begin
      count_next       = waiting_count - CW'(1);
      server_time_next = fin;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_count <= '0;
      server_time   <= '0;
      for (int c = 0; c < tcpq_pkg::NUM_CLASSES; c++) begin
        drops_per_class[c]    <= '0;
        served_per_class[c]   <= '0;
        wait_sum_per_class[c] <= '0;
      end
    end else if (cmd.commit) begin
      waiting_count <= count_next;
      server_time   <= server_time_next;
      if (drop_cls) begin
        drops_per_class[cidx] <= drop_new;
      end
      if (srv_ok) begin
        served_per_class[cidx]   <= served_new;
        wait_sum_per_class[cidx] <= wsum_new;
      end
    end
  end

  // cells: write at the tail, close the gap on serve
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.commit && enq_ok && (waiting_count == CW'(g))) begin
          slot_class[g]   <= cls_r;
          slot_service[g] <= svc_r;
          slot_arrival[g] <= arr_r;
        end else if (cmd.commit && srv_ok && shift_r[g]) begin
          slot_class[g]   <= slot_class[g+1];
          slot_service[g] <= slot_service[g+1];
          slot_arrival[g] <= slot_arrival[g+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.commit && enq_ok && (waiting_count == CW'(g))) begin
          slot_class[g]   <= cls_r;
          slot_service[g] <= svc_r;
          slot_arrival[g] <= arr_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status            <= res_status;
      rsp.item_class        <= res_cls;
      rsp.item_service_time <= srv_ok ? p_svc_r : 3'd0;
      rsp.wait_time         <= srv_ok ? wait_t : 16'd0;
      rsp.finish_time       <= server_time_next;
      rsp.occupancy         <= 4'(count_next);
      if (res_cls == tcpq_pkg::CLASS_NONE) begin
        rsp.class_drop_count   <= '0;
        rsp.class_served_count <= '0;
        rsp.class_wait_sum     <= '0;
      end else begin
        rsp.class_drop_count   <= drop_new;
        rsp.class_served_count <= served_new;
        rsp.class_wait_sum     <= wsum_new;
      end
    end
  end

endmodule

// ===== design/tcpq_ctrl.sv =====
// two-state controller: capture an item, then commit it when the result slot is free
// depends on tcpq_pkg
module tcpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tcpq_pkg::cmd_t cmd
);

  typedef enum logic {S_IDLE, S_COMMIT} state_t;

  state_t state;

  always_comb begin
    cmd.load   = req_valid && !req_stall;
    cmd.commit = (state == S_COMMIT) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_stall <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state     <= S_COMMIT;
            req_stall <= 1'b1;
          end
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state     <= S_IDLE;
            req_stall <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          req_stall <= 1'b0;
        end
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/three_class_priority_queue_server_core.sv =====
// top level of the three-class strict priority queue server
// depends on tcpq_pkg, tcpq_ctrl, tcpq_datapath
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+----------------------------
//   request | req_valid | req_stall | req (tcpq_pkg::req_t)
//   result  | rsp_valid | rsp_stall | rsp (tcpq_pkg::rsp_t)
//
// for each item, the accept edge captures it and registers the
//   pick of the oldest best-class entry; the commit edge then applies the update
// the commit waits while a prior result is held by rsp_stall; meanwhile
//   req_stall stays high, so at most one item is in flight
// one result per item, in order; the result register frees when taken
// rst is synchronous: queue empty, server time and all class counters zero
module three_class_priority_queue_server_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tcpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tcpq_pkg::rsp_t rsp
);

  // commands from the controller to the datapath
  tcpq_pkg::cmd_t cmd;

  // sequencing and handshake
  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // queue cells, server clock, class counters and result register
  tcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== design/tcpq_checker.sv =====
// port-level checks for the priority queue server, bound to the top level
// depends on tcpq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tcpq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input tcpq_pkg::rsp_t rsp
);

  logic rsp_held, req_take, empty_rsp, empty_clean, stored_rsp;

  assign rsp_held    = rsp_valid && rsp_stall;
  assign req_take    = req_valid && !req_stall;
  assign empty_rsp   = rsp_valid && (rsp.status == tcpq_pkg::ST_EMPTY);
  assign empty_clean = (rsp.item_class == tcpq_pkg::CLASS_NONE) && (rsp.wait_time == 16'd0) &&
                       (rsp.item_service_time == 3'd0) && (rsp.class_drop_count == 16'd0) &&
                       (rsp.class_served_count == 16'd0) && (rsp.class_wait_sum == 32'd0);
  assign stored_rsp  = rsp_valid && ((rsp.status == tcpq_pkg::ST_ACCEPTED) ||
                                     (rsp.status == tcpq_pkg::ST_SERVED));

  // a held result keeps its payload
  `CHK_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "result changed while stalled")

  // one item in flight: the cycle after an accept is stalled
  `CHK_NEXT(a_one_in_flight, req_take, req_stall, "items accepted back to back")

  // an empty serve reports no entry and no counters
  `CHK_ALWAYS(a_empty_clean, !empty_rsp || empty_clean, "empty result carries data")

  // accepted and served entries always carry a real class
  `CHK_ALWAYS(a_class_real, !stored_rsp || (rsp.item_class != tcpq_pkg::CLASS_NONE), "no class")

endmodule

bind three_class_priority_queue_server_core tcpq_checker u_tcpq_checker (.*);

// ===== tb/sv/tb_three_class_priority_queue_server_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the three-class priority queue server: a directed table,
// then randomized enqueue/serve traffic, checked against typed results or a behavioral queue model
// depends on tcpq_pkg and three_class_priority_queue_server_core
module tb_three_class_priority_queue_server_core;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 930;
  localparam int TAIL_ITEMS   = 40;       // last random items arrive at the top of the clock
  localparam int SETTLE       = 8;        // quiet cycles after the last result
  localparam int TIME_MAX     = 65535;
  localparam int COUNT_MAX    = 65535;
  localparam longint unsigned WAIT_SUM_MAX = 64'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // one directed row; want is only used where typed is set
  typedef struct {
    tcpq_pkg::req_t item;
    bit             drain;
    bit             typed;
    tcpq_pkg::rsp_t want;
  } row_t;

  logic           clk;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  tcpq_pkg::req_t req       = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  tcpq_pkg::rsp_t rsp;

  three_class_priority_queue_server_core #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // behavioral copy of the queue, kept in arrival order
  logic [1:0]      held_class   [DEPTH];
  logic [2:0]      held_service [DEPTH];
  logic [15:0]     held_arrival [DEPTH];
  int              queue_len    = 0;
  int              server_clock = 0;
  int unsigned     drop_tally   [1:3] = '{0, 0, 0};
  int unsigned     served_tally [1:3] = '{0, 0, 0};
  longint unsigned wait_total   [1:3] = '{0, 0, 0};

  tcpq_pkg::rsp_t pending_results [$];
  row_t           directed_rows   [$];
  int unsigned    cycle_count  = 0;
  int             error_count  = 0;
  int             results_seen = 0;
  int             status_tally [4] = '{0, 0, 0, 0};
  int             full_drops   = 0;
  int             longest_wait = 0;

  // idle pacing state of each side
  bit send_calm    = 1'b0;
  int send_stretch = 30;
  bit recv_calm    = 1'b0;
  int recv_stretch = 45;
  int hold_left    = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // result of one item, updating the queue copy
  function automatic tcpq_pkg::rsp_t next_queue_result(input tcpq_pkg::req_t r);
    tcpq_pkg::rsp_t o;
    int             i, pick, start, fin, waited;
    o = '0;
    if (r.opcode == tcpq_pkg::OP_ENQUEUE) begin
      if (r.entry_class == tcpq_pkg::CLASS_NONE) begin
        // class none is refused without touching any counter
        o.status = tcpq_pkg::ST_DROPPED;
      end else if (queue_len == DEPTH) begin
        o.status     = tcpq_pkg::ST_DROPPED;
        o.item_class = r.entry_class;
        if (drop_tally[r.entry_class] < COUNT_MAX) drop_tally[r.entry_class]++;
      end else begin
        o.status     = tcpq_pkg::ST_ACCEPTED;
        o.item_class = r.entry_class;
        held_class[queue_len]   = r.entry_class;
        held_service[queue_len] = r.service_time;
        held_arrival[queue_len] = r.arrival_time;
        queue_len++;
      end
    end else if (queue_len == 0) begin
      o.status = tcpq_pkg::ST_EMPTY;
    end else begin
      // strict compare keeps the oldest entry of the best class
      pick = 0;
      for (i = 1; i < queue_len; i++)
        if (held_class[i] < held_class[pick]) pick = i;
      start  = (held_arrival[pick] > server_clock) ? int'(held_arrival[pick]) : server_clock;
      waited = start - int'(held_arrival[pick]);
      fin    = start + int'(held_service[pick]);
      server_clock = (fin > TIME_MAX) ? TIME_MAX : fin;
      o.status            = tcpq_pkg::ST_SERVED;
      o.item_class        = held_class[pick];
      o.item_service_time = held_service[pick];
      o.wait_time         = 16'(waited);
      if (served_tally[o.item_class] < COUNT_MAX) served_tally[o.item_class]++;
      if (wait_total[o.item_class] + longint'(waited) > WAIT_SUM_MAX)
        wait_total[o.item_class] = WAIT_SUM_MAX;
      else
        wait_total[o.item_class] = wait_total[o.item_class] + longint'(waited);
      for (i = pick; i < queue_len - 1; i++) begin
        held_class[i]   = held_class[i + 1];
        held_service[i] = held_service[i + 1];
        held_arrival[i] = held_arrival[i + 1];
      end
      queue_len--;
      if (waited > longest_wait) longest_wait = waited;
    end
    o.finish_time = 16'(server_clock);
    o.occupancy   = 4'(queue_len);
    if (o.item_class != tcpq_pkg::CLASS_NONE) begin
      o.class_drop_count   = 16'(drop_tally[o.item_class]);
      o.class_served_count = 16'(served_tally[o.item_class]);
      o.class_wait_sum     = 32'(wait_total[o.item_class]);
    end
    return o;
  endfunction

  function automatic tcpq_pkg::rsp_t typed_result(input logic [1:0] status,
                                                  input logic [1:0] cls, input int svc,
                                                  input int waited, input int finish,
                                                  input int occ, input int drops,
                                                  input int served,
                                                  input longint unsigned wsum);
    tcpq_pkg::rsp_t o;
    o.status             = status;
    o.item_class         = cls;
    o.item_service_time  = 3'(svc);
    o.wait_time          = 16'(waited);
    o.finish_time        = 16'(finish);
    o.occupancy          = 4'(occ);
    o.class_drop_count   = 16'(drops);
    o.class_served_count = 16'(served);
    o.class_wait_sum     = 32'(wsum);
    return o;
  endfunction

  task automatic add_row(input logic op, input logic [1:0] cls, input logic [2:0] svc,
                         input logic [15:0] arr, input bit drain, input bit typed,
                         input tcpq_pkg::rsp_t want);
    row_t row;
    row.item.opcode       = op;
    row.item.entry_class  = cls;
    row.item.service_time = svc;
    row.item.arrival_time = arr;
    row.drain = drain;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // mostly short gaps, some medium, a few long
  function automatic int idle_cycles(input bit calm);
    int roll;
    roll = int'($urandom_range(0, 99));
    if (calm || roll < 55) return 0;
    if (roll < 88) return int'($urandom_range(1, 3));
    if (roll < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // present one item, hold it until taken, then queue its expected result
  task automatic offer_request(input tcpq_pkg::req_t item, input bit typed,
                               input tcpq_pkg::rsp_t want);
    int             gap;
    tcpq_pkg::rsp_t predicted;
    send_stretch--;
    if (send_stretch <= 0) begin
      send_calm    = ($urandom_range(0, 3) == 0);
      send_stretch = int'($urandom_range(20, 80));
    end
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    predicted = next_queue_result(item);
    status_tally[predicted.status]++;
    if (predicted.status == tcpq_pkg::ST_DROPPED &&
        predicted.item_class != tcpq_pkg::CLASS_NONE) full_drops++;
    pending_results.push_back(typed ? want : predicted);
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic wait_for_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic check_result(input tcpq_pkg::rsp_t got);
    tcpq_pkg::rsp_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      error_count++;
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("item_class", 32'(want.item_class), 32'(got.item_class));
    check_field("item_service_time", 32'(want.item_service_time),
                32'(got.item_service_time));
    check_field("wait_time", 32'(want.wait_time), 32'(got.wait_time));
    check_field("finish_time", 32'(want.finish_time), 32'(got.finish_time));
    check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    check_field("class_drop_count", 32'(want.class_drop_count),
                32'(got.class_drop_count));
    check_field("class_served_count", 32'(want.class_served_count),
                32'(got.class_served_count));
    check_field("class_wait_sum", want.class_wait_sum, got.class_wait_sum);
  endtask

  // result side: take items, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_result(rsp);
    recv_stretch--;
    if (recv_stretch <= 0) begin
      recv_calm    = ($urandom_range(0, 3) == 0);
      recv_stretch = int'($urandom_range(20, 80));
    end
    if (hold_left > 0) hold_left--;
    else hold_left = idle_cycles(recv_calm);
    rsp_stall <= (hold_left > 0);
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    row_t           row;
    tcpq_pkg::req_t item;
    int             tick, step, upper;
    bit             filling;

    // serve on an empty queue right after reset
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_NONE, 3'd0, 16'h0000, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_EMPTY, tcpq_pkg::CLASS_NONE, 0, 0, 0, 0, 0, 0, 0));
    // class none is refused, nothing counted
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_NONE, 3'd7, 16'hFFFF, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_DROPPED, tcpq_pkg::CLASS_NONE, 0, 0, 0, 0, 0, 0, 0));
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_LO, 3'd1, 16'd10, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_ACCEPTED, tcpq_pkg::CLASS_LO, 0, 0, 0, 1, 0, 0, 0));
    // fill the rest, classes interleaved, one zero service time
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_MID, 3'd0, 16'd0,   1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_HI,  3'd7, 16'd20,  1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_LO,  3'd5, 16'd5,   1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_HI,  3'd2, 16'd3,   1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_MID, 3'd6, 16'd40,  1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_LO,  3'd3, 16'd100, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_HI,  3'd4, 16'd50,  1'b0, 1'b0, '0);
    // queue full: drops are counted per class
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_MID, 3'd7, 16'hFFFF, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_DROPPED, tcpq_pkg::CLASS_MID, 0, 0, 0, DEPTH, 1, 0, 0));
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_HI, 3'd0, 16'h0000, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_DROPPED, tcpq_pkg::CLASS_HI, 0, 0, 0, DEPTH, 1, 0, 0));
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_LO, 3'd7, 16'h5555, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_DROPPED, tcpq_pkg::CLASS_LO, 0, 0, 0, DEPTH, 1, 0, 0));
    add_row(tcpq_pkg::OP_ENQUEUE, tcpq_pkg::CLASS_NONE, 3'd0, 16'hAAAA, 1'b0, 1'b1,
            typed_result(tcpq_pkg::ST_DROPPED, tcpq_pkg::CLASS_NONE, 0, 0, 0, DEPTH, 0, 0, 0));
    // drain everything after a full pause; serve ignores the entry fields
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_LO,   3'd7, 16'hFFFF, 1'b1, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_NONE, 3'd0, 16'h0000, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_MID,  3'd5, 16'hAAAA, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_HI,   3'd2, 16'h5555, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_LO,   3'd1, 16'h1234, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_MID,  3'd6, 16'h8000, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_HI,   3'd3, 16'h0001, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_LO,   3'd4, 16'h7FFF, 1'b0, 1'b0, '0);
    add_row(tcpq_pkg::OP_SERVE, tcpq_pkg::CLASS_NONE, 3'd7, 16'hFFFF, 1'b0, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.drain) wait_for_results();
      offer_request(row.item, row.typed, row.want);
    end

    // random traffic: arrivals ramp across the whole 16-bit clock, fill and
    // drain phases alternate, a minority of items are malformed noise
    tick    = 0;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - TAIL_ITEMS) begin
        // pile up at the top so the server clock saturates
        tick = TIME_MAX - int'($urandom_range(0, 8));
      end else begin
        step = int'($urandom_range(0, 150));
        tick = (tick + step > TIME_MAX) ? TIME_MAX : tick + step;
      end
      if ($urandom_range(0, 99) < 12) begin
        // noise: class none, zero service, out-of-order or early arrivals
        upper = (tick > TIME_MAX - 2048) ? TIME_MAX : tick + 2048;
        item.opcode       = 1'($urandom_range(0, 1));
        item.entry_class  = 2'($urandom_range(0, 3));
        item.service_time = 3'($urandom_range(0, 7));
        item.arrival_time = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, tick))
                                                        : 16'($urandom_range(tick, upper));
      end else begin
        item.opcode       = ($urandom_range(0, 99) < (filling ? 25 : 70)) ?
                            tcpq_pkg::OP_SERVE : tcpq_pkg::OP_ENQUEUE;
        item.entry_class  = 2'($urandom_range(tcpq_pkg::CLASS_HI, tcpq_pkg::CLASS_LO));
        item.service_time = 3'($urandom_range(1, 7));
        item.arrival_time = 16'(tick);
      end
      if ($urandom_range(0, 99) == 0) wait_for_results();
      offer_request(item, 1'b0, '0);
      if (queue_len == DEPTH) filling = 1'b0;
      else if (queue_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 31) == 0) filling = !filling;
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d items: %0d accepted, %0d dropped (%0d on a full queue),",
             results_seen, status_tally[tcpq_pkg::ST_ACCEPTED],
             status_tally[tcpq_pkg::ST_DROPPED], full_drops);
    $display("%0d served, %0d empty serves, longest wait %0d, server clock %0d, %0d mismatches",
             status_tally[tcpq_pkg::ST_SERVED], status_tally[tcpq_pkg::ST_EMPTY],
             longest_wait, server_clock, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== three_class_priority_queue_server_core.f =====
+incdir+design
design/tcpq_pkg.sv
design/tcpq_datapath.sv
design/tcpq_ctrl.sv
design/three_class_priority_queue_server_core.sv
design/tcpq_checker.sv
tb/sv/tb_three_class_priority_queue_server_core.sv
